// File: rtl/annexb_nal_splitter_checker_defines.svh
// Assertion macros shared by the Annex-B splitter RTL.
`ifndef ANNEXB_NAL_SPLITTER_CHECKER_DEFINES_SVH
`define ANNEXB_NAL_SPLITTER_CHECKER_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define ANB_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and disabled during reset.
`define ANB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/annexb_pkg.sv
// Constants, status codes and the unit check for the Annex-B splitter.
package annexb_pkg;

	localparam int LENGTH_BITS_DEFAULT = 16;

	localparam logic [7:0] TYPE_MASK     = 8'h1f;
	localparam logic [7:0] FORBIDDEN_BIT = 8'h80;
	localparam logic [4:0] TYPE_SPS      = 5'd7;
	localparam logic [4:0] TYPE_PPS      = 5'd8;
	localparam int         SPS_MIN_LEN   = 4;
	localparam logic [15:0] REPORT_MAX   = 16'hffff;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_START  = 3'd1;
	localparam logic [2:0] ST_EMPTY     = 3'd2;
	localparam logic [2:0] ST_FORBIDDEN = 3'd3;
	localparam logic [2:0] ST_SPS_SHORT = 3'd4;
	localparam logic [2:0] ST_DISAGREE  = 3'd5;
	localparam logic [2:0] ST_MISSING   = 3'd6;

	// Checks on a closed unit, applied in priority order.
	function automatic logic [2:0] unit_check(input logic [7:0] first, input logic empty,
			input logic short_sps, input logic differ, input logic have_profile);
		logic [4:0] nal_type;
		logic [2:0] code;
		nal_type = 5'(first & TYPE_MASK);
		code = ST_OK;
		if (empty) begin
			code = ST_EMPTY;
		end else if ((first & FORBIDDEN_BIT) != 8'h00) begin
			code = ST_FORBIDDEN;
		end else if (nal_type == TYPE_SPS) begin
			if (short_sps) begin
				code = ST_SPS_SHORT;
			end else if (have_profile && differ) begin
				code = ST_DISAGREE;
			end
		end
		return code;
	endfunction

endpackage

// File: rtl/annexb_nal_splitter_checker.sv
// H.264 Annex-B start code splitter with SPS/PPS stream checks.
// Accepts one stream byte per cycle on a valid/stall channel and sustains one byte per
// clock unless a result is held by out_stall; a result passes the input register and the
// single state-update stage that writes the result register. A result appears when
// a start code closes a unit and on the byte marked final_byte; other bytes give none.
// After a start-code close, unit_valid, unit_header and unit_length describe the closed
// unit; status_code holds the first error of the stream and sticks until the final byte,
// after which all state returns to reset and the next byte opens a new stream. Unit
// lengths count up to 2^LENGTH_BITS - 1 and are reported capped at 65535.
`include "annexb_nal_splitter_checker_defines.svh"

module annexb_nal_splitter_checker #(
	parameter int LENGTH_BITS = annexb_pkg::LENGTH_BITS_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       unit_valid,
	output logic [7:0] unit_header,
	output logic [15:0] unit_length,
	output logic       stream_done,
	output logic [2:0] status_code,
	output logic [7:0] profile_idc,
	output logic [7:0] constraint_flags,
	output logic [7:0] level_idc,
	output logic       sps_seen,
	output logic       pps_seen
);
	import annexb_pkg::*;

	typedef enum logic [1:0] {PH_SEEK, PH_UNIT, PH_HALT} phase_t;

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

	// Input register.
	logic       v_s1;
	logic [7:0] byte_s1;
	logic       fin_s1;

	// Running stream state.
	phase_t                 phase_q;
	logic [1:0]             zero_run_q;
	logic [LENGTH_BITS-1:0] unit_count_q;
	logic [LENGTH_BITS-1:0] raw_count_q;
	logic [7:0]             unit_first_q;
	logic [23:0]            cand_q;
	logic                   have_profile_q;
	logic [23:0]            stored_q;
	logic                   seen_sps_q;
	logic                   seen_pps_q;
	logic [2:0]             err_q;

	// Result register.
	logic        out_valid_q;
	logic        unit_valid_q;
	logic [7:0]  unit_header_q;
	logic [15:0] unit_length_q;
	logic        done_q;
	logic [2:0]  status_q;
	logic [23:0] triple_q;
	logic        sps_q;
	logic        pps_q;

	// Next-state values.
	phase_t                 n_phase;
	logic [1:0]             n_zero_run;
	logic [LENGTH_BITS-1:0] n_unit_count;
	logic [LENGTH_BITS-1:0] n_raw_count;
	logic [7:0]             n_unit_first;
	logic [23:0]            n_cand;
	logic                   n_have_profile;
	logic [23:0]            n_stored;
	logic                   n_seen_sps;
	logic                   n_seen_pps;
	logic [2:0]             n_err;
	logic                   closed;
	logic                   has_result;
	logic                   rep_valid;
	logic [7:0]             rep_header;
	logic [15:0]            rep_length;

	logic consume;
	logic load_in;

	always_comb begin
		logic [2:0]  code;
		logic [4:0]  nal_type;
		logic [31:0] len_wide;
		n_phase        = phase_q;
		n_zero_run     = zero_run_q;
		n_unit_count   = unit_count_q;
		n_raw_count    = raw_count_q;
		n_unit_first   = unit_first_q;
		n_cand         = cand_q;
		n_have_profile = have_profile_q;
		n_stored       = stored_q;
		n_seen_sps     = seen_sps_q;
		n_seen_pps     = seen_pps_q;
		n_err          = err_q;
		closed         = 1'b0;
		rep_valid      = 1'b0;
		rep_header     = 8'h00;
		rep_length     = 16'h0000;
		code           = ST_OK;
		nal_type       = 5'(n_unit_first & TYPE_MASK);
		len_wide       = 32'h0;

		case (phase_q)
			PH_SEEK: begin
				if (byte_s1 == 8'h00) begin
					if (zero_run_q != 2'd3) n_zero_run = zero_run_q + 2'd1;
				end else if (byte_s1 == 8'h01 && zero_run_q >= 2'd2) begin
					n_phase      = PH_UNIT;
					n_zero_run   = 2'd0;
					n_unit_count = '0;
					n_raw_count  = '0;
					n_unit_first = 8'h00;
					n_cand       = 24'h0;
				end else begin
					if (n_err == ST_OK) n_err = ST_NO_START;
					n_phase = PH_HALT;
				end
			end
			PH_UNIT: begin
				if (byte_s1 == 8'h01 && zero_run_q >= 2'd2) begin
					closed = 1'b1;
				end else begin
					if (raw_count_q == '0) n_unit_first = byte_s1;
					// Bytes one to three of the unit form the profile triple.
					if (raw_count_q == LENGTH_BITS'(1)) n_cand[23:16] = byte_s1;
					if (raw_count_q == LENGTH_BITS'(2)) n_cand[15:8]  = byte_s1;
					if (raw_count_q == LENGTH_BITS'(3)) n_cand[7:0]   = byte_s1;
					if (raw_count_q != LEN_MAX) n_raw_count = raw_count_q + LENGTH_BITS'(1);
					if (byte_s1 != 8'h00) begin
						n_unit_count = n_raw_count;
						n_zero_run   = 2'd0;
					end else if (zero_run_q != 2'd3) begin
						n_zero_run = zero_run_q + 2'd1;
					end
				end
			end
			default: begin
			end
		endcase

		// A unit closes on a start code, or at the final byte while inside a unit.
		if (closed || (fin_s1 && n_phase == PH_UNIT)) begin
			nal_type = 5'(n_unit_first & TYPE_MASK);
			code = unit_check(n_unit_first, n_unit_count == '0,
				n_unit_count < LENGTH_BITS'(SPS_MIN_LEN), n_cand != n_stored,
				n_have_profile);
			rep_header = n_unit_first;
			len_wide   = 32'(n_unit_count);
			rep_length = (len_wide > 32'(REPORT_MAX)) ? REPORT_MAX : len_wide[15:0];
			rep_valid  = (code == ST_OK);
			if (code != ST_OK) begin
				if (n_err == ST_OK) n_err = code;
				n_phase = PH_HALT;
			end else if (nal_type == TYPE_SPS) begin
				n_stored       = n_cand;
				n_have_profile = 1'b1;
				n_seen_sps     = 1'b1;
			end else if (nal_type == TYPE_PPS) begin
				n_seen_pps = 1'b1;
			end
		end

		if (closed && n_phase == PH_UNIT) begin
			n_zero_run   = 2'd0;
			n_unit_count = '0;
			n_raw_count  = '0;
			n_unit_first = 8'h00;
			n_cand       = 24'h0;
		end

		if (fin_s1) begin
			if (n_phase == PH_SEEK) begin
				if (n_err == ST_OK) n_err = ST_NO_START;
			end else if (closed && n_phase == PH_UNIT) begin
				// The final byte completed a start code, so the unit it opened is empty.
				if (n_err == ST_OK) n_err = ST_EMPTY;
			end
			if (n_err == ST_OK && !(n_seen_sps && n_seen_pps)) n_err = ST_MISSING;
		end

		has_result = closed || fin_s1;
	end

	assign consume  = v_s1 && (!has_result || !out_valid_q || !out_stall);
	assign in_stall = v_s1 && !consume;
	assign load_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1           <= 1'b0;
			phase_q        <= PH_SEEK;
			zero_run_q     <= 2'd0;
			unit_count_q   <= '0;
			raw_count_q    <= '0;
			unit_first_q   <= 8'h00;
			cand_q         <= 24'h0;
			have_profile_q <= 1'b0;
			stored_q       <= 24'h0;
			seen_sps_q     <= 1'b0;
			seen_pps_q     <= 1'b0;
			err_q          <= ST_OK;
			out_valid_q    <= 1'b0;
		end else begin
			if (load_in) begin
				v_s1    <= 1'b1;
				byte_s1 <= data_byte;
				fin_s1  <= final_byte;
			end else if (consume) begin
				v_s1 <= 1'b0;
			end

			if (consume) begin
				if (fin_s1) begin
					phase_q        <= PH_SEEK;
					zero_run_q     <= 2'd0;
					unit_count_q   <= '0;
					raw_count_q    <= '0;
					unit_first_q   <= 8'h00;
					cand_q         <= 24'h0;
					have_profile_q <= 1'b0;
					stored_q       <= 24'h0;
					seen_sps_q     <= 1'b0;
					seen_pps_q     <= 1'b0;
					err_q          <= ST_OK;
				end else begin
					phase_q        <= n_phase;
					zero_run_q     <= n_zero_run;
					unit_count_q   <= n_unit_count;
					raw_count_q    <= n_raw_count;
					unit_first_q   <= n_unit_first;
					cand_q         <= n_cand;
					have_profile_q <= n_have_profile;
					stored_q       <= n_stored;
					seen_sps_q     <= n_seen_sps;
					seen_pps_q     <= n_seen_pps;
					err_q          <= n_err;
				end
			end

			if (consume && has_result) begin
				out_valid_q   <= 1'b1;
				unit_valid_q  <= rep_valid;
				unit_header_q <= rep_header;
				unit_length_q <= rep_length;
				done_q        <= fin_s1;
				status_q      <= n_err;
				triple_q      <= n_stored;
				sps_q         <= n_seen_sps;
				pps_q         <= n_seen_pps;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign unit_valid       = unit_valid_q;
	assign unit_header      = unit_header_q;
	assign unit_length      = unit_length_q;
	assign stream_done      = done_q;
	assign status_code      = status_q;
	assign profile_idc      = triple_q[23:16];
	assign constraint_flags = triple_q[15:8];
	assign level_idc        = triple_q[7:0];
	assign sps_seen         = sps_q;
	assign pps_seen         = pps_q;

	`ANB_ASSERT_NEXT(a_reset_after_final, consume && fin_s1, phase_q == PH_SEEK && err_q == ST_OK, "state not cleared after final item")
	`ANB_ASSERT_IMPLIES(a_halt_has_error, phase_q == PH_HALT, err_q != ST_OK, "halted without an error code")
	`ANB_ASSERT_IMPLIES(a_done_ok_seen, out_valid && stream_done && status_code == ST_OK, sps_seen && pps_seen, "clean stream end without SPS and PPS")
	`ANB_ASSERT_IMPLIES(a_valid_unit_nonempty, out_valid && unit_valid, unit_length != 16'h0000, "valid unit reported with zero length")
	`ANB_ASSERT_IMPLIES(a_stall_needs_item, in_stall, v_s1 && has_result && out_valid_q, "input stalled without a blocked item")

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the Annex-B start code splitter and parameter-set checker.
`timescale 1ns / 100ps

module tb_top;
	import annexb_pkg::*;

	typedef enum logic [1:0] {SEEKING, IN_UNIT, HALTED} scan_phase_t;

	typedef struct packed {
		logic        uvalid;
		logic [7:0]  hdr;
		logic [15:0] len;
		logic        done;
		logic [2:0]  status;
		logic [7:0]  prof;
		logic [7:0]  cons;
		logic [7:0]  lvl;
		logic        sps;
		logic        pps;
	} nal_report_t;

	typedef struct packed {
		logic [7:0]  b;
		logic        fin;
		logic        typed;
		nal_report_t want;
	} dir_row_t;

	localparam int LEN_CAP = (1 << LENGTH_BITS_DEFAULT) - 1;

	// Rows with typed = 1 carry their expected report; the others use the predictor.
	localparam dir_row_t DIRECTED_ROWS [27] = '{
		'{8'h05, 1'b1, 1'b1,
			'{1'b0, 8'h00, 16'd0, 1'b1, ST_NO_START, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0}},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h01, 1'b1, 1'b1,
			'{1'b0, 8'h00, 16'd0, 1'b1, ST_NO_START, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0}},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h01, 1'b0, 1'b0, '0},
		'{8'h67, 1'b0, 1'b0, '0},
		'{8'h42, 1'b0, 1'b0, '0},
		'{8'hc0, 1'b0, 1'b0, '0},
		'{8'h1e, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h01, 1'b0, 1'b0, '0},
		'{8'h68, 1'b0, 1'b0, '0},
		'{8'hce, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h01, 1'b0, 1'b0, '0},
		'{8'hff, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h01, 1'b0, 1'b1,
			'{1'b0, 8'hff, 16'd1, 1'b0, ST_FORBIDDEN, 8'h42, 8'hc0, 8'h1e, 1'b1, 1'b1}},
		'{8'h00, 1'b1, 1'b1,
			'{1'b0, 8'h00, 16'd0, 1'b1, ST_FORBIDDEN, 8'h42, 8'hc0, 8'h1e, 1'b1, 1'b1}},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h01, 1'b1, 1'b1,
			'{1'b0, 8'h00, 16'd0, 1'b1, ST_EMPTY, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        final_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        unit_valid;
	logic [7:0]  unit_header;
	logic [15:0] unit_length;
	logic        stream_done;
	logic [2:0]  status_code;
	logic [7:0]  profile_idc;
	logic [7:0]  constraint_flags;
	logic [7:0]  level_idc;
	logic        sps_seen;
	logic        pps_seen;

	nal_report_t pending_reports[$];
	bit [7:0]    stream_bytes[$];
	bit          idling;
	bit          failed = 1'b0;
	int          bytes_examined;
	int          hold_cycles;

	// Splitter state as the predictor sees it.
	scan_phase_t scan_ph;
	int          zeros;
	int          kept_len;
	int          raw_len;
	logic [7:0]  lead_byte;
	logic [23:0] cand_trip;
	logic        trip_valid;
	logic [23:0] stored_trip;
	logic        got_sps;
	logic        got_pps;
	logic [2:0]  first_err;
	logic        rpt_ok;
	logic [7:0]  rpt_hdr;
	int          rpt_len;

	annexb_nal_splitter_checker dut (.*);

	always #5 clk = ~clk;

	function automatic void latch_error(input logic [2:0] code);
		if (first_err == ST_OK)
			first_err = code;
	endfunction

	function automatic void open_unit();
		zeros = 0;
		kept_len = 0;
		raw_len = 0;
		lead_byte = 8'h00;
		cand_trip = 24'h0;
	endfunction

	function automatic void clear_splitter();
		scan_ph = SEEKING;
		open_unit();
		trip_valid = 1'b0;
		stored_trip = 24'h0;
		got_sps = 1'b0;
		got_pps = 1'b0;
		first_err = ST_OK;
	endfunction

	function automatic void close_unit();
		logic [2:0] code;
		code = ST_OK;
		rpt_hdr = lead_byte;
		rpt_len = kept_len;
		if (kept_len == 0) begin
			code = ST_EMPTY;
		end else if ((lead_byte & FORBIDDEN_BIT) != 8'h00) begin
			code = ST_FORBIDDEN;
		end else if ((lead_byte & TYPE_MASK) == TYPE_SPS) begin
			if (kept_len < SPS_MIN_LEN) begin
				code = ST_SPS_SHORT;
			end else if (trip_valid && cand_trip != stored_trip) begin
				code = ST_DISAGREE;
			end else begin
				stored_trip = cand_trip;
				trip_valid = 1'b1;
				got_sps = 1'b1;
			end
		end else if ((lead_byte & TYPE_MASK) == TYPE_PPS) begin
			got_pps = 1'b1;
		end
		rpt_ok = (code == ST_OK);
		if (code != ST_OK) begin
			latch_error(code);
			scan_ph = HALTED;
		end
	endfunction

	function automatic void predict_splitter(input bit [7:0] b, input bit fin,
			output bit has_rpt, output nal_report_t r);
		bit closed;
		closed = 1'b0;
		rpt_ok = 1'b0;
		rpt_hdr = 8'h00;
		rpt_len = 0;
		case (scan_ph)
			SEEKING: begin
				if (b == 8'h00) begin
					if (zeros < 3)
						zeros++;
				end else if (b == 8'h01 && zeros >= 2) begin
					scan_ph = IN_UNIT;
					open_unit();
				end else begin
					latch_error(ST_NO_START);
					scan_ph = HALTED;
				end
			end
			IN_UNIT: begin
				if (b == 8'h01 && zeros >= 2) begin
					close_unit();
					closed = 1'b1;
					if (scan_ph == IN_UNIT)
						open_unit();
				end else begin
					if (raw_len == 0)
						lead_byte = b;
					if (raw_len >= 1 && raw_len <= 3)
						cand_trip |= 24'(b) << (8 * (3 - raw_len));
					if (raw_len < LEN_CAP)
						raw_len++;
					// Trailing zeros do not count until a nonzero byte follows them.
					if (b != 8'h00) begin
						kept_len = raw_len;
						zeros = 0;
					end else if (zeros < 3) begin
						zeros++;
					end
				end
			end
			default: ;
		endcase
		has_rpt = fin || closed;
		if (fin) begin
			if (scan_ph == SEEKING) begin
				latch_error(ST_NO_START);
			end else if (scan_ph == IN_UNIT) begin
				if (closed)
					latch_error(ST_EMPTY);
				else
					close_unit();
			end
			if (first_err == ST_OK && !(got_sps && got_pps))
				latch_error(ST_MISSING);
		end
		r = '{rpt_ok, rpt_hdr, (rpt_len > REPORT_MAX) ? REPORT_MAX : 16'(rpt_len), fin,
			first_err, stored_trip[23:16], stored_trip[15:8], stored_trip[7:0],
			got_sps, got_pps};
		if (fin)
			clear_splitter();
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			failed = 1'b1;
		end
	endfunction

	// Output side: checks each accepted report and stalls at random after it.
	always @(posedge clk or negedge arst_n) begin
		nal_report_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_cycles = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_reports.size() == 0) begin
					$error("report accepted with no expected report waiting");
					failed = 1'b1;
				end else begin
					want = pending_reports.pop_front();
					check_field("unit_valid", 16'(want.uvalid), 16'(unit_valid));
					check_field("unit_header", 16'(want.hdr), 16'(unit_header));
					check_field("unit_length", want.len, unit_length);
					check_field("stream_done", 16'(want.done), 16'(stream_done));
					check_field("status_code", 16'(want.status), 16'(status_code));
					check_field("profile_idc", 16'(want.prof), 16'(profile_idc));
					check_field("constraint_flags", 16'(want.cons),
						16'(constraint_flags));
					check_field("level_idc", 16'(want.lvl), 16'(level_idc));
					check_field("sps_seen", 16'(want.sps), 16'(sps_seen));
					check_field("pps_seen", 16'(want.pps), 16'(pps_seen));
				end
				hold_cycles = idling ? $urandom_range(0, 7) : 0;
			end else if (hold_cycles > 0) begin
				hold_cycles--;
			end
			out_stall <= (hold_cycles > 0);
		end
	end

	task automatic push_byte(input bit [7:0] b, input bit fin, input bit given,
			input nal_report_t want);
		int gap;
		bit has_rpt;
		nal_report_t r;
		gap = idling ? $urandom_range(0, 7) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		final_byte <= fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (scan_ph != HALTED)
			bytes_examined++;
		predict_splitter(b, fin, has_rpt, r);
		if (has_rpt)
			pending_reports.insert(pending_reports.size(), given ? want : r);
	endtask

	task automatic drain_reports();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_reports.size() != 0);
	endtask

	function automatic void put_byte(input bit [7:0] b);
		stream_bytes.insert(stream_bytes.size(), b);
	endfunction

	// Appends one byte of unit content, never letting it complete a start code.
	function automatic void add_byte(input bit [7:0] b);
		int n;
		n = stream_bytes.size();
		if (b == 8'h01 && n >= 2 && stream_bytes[n - 1] == 8'h00
				&& stream_bytes[n - 2] == 8'h00)
			b = 8'h02;
		put_byte(b);
	endfunction

	function automatic void add_start();
		repeat ($urandom_range(2, 4))
			put_byte(8'h00);
		put_byte(8'h01);
	endfunction

	function automatic bit [7:0] nal_hdr(input bit [4:0] ntype);
		return {1'b0, 2'($urandom_range(0, 3)), ntype};
	endfunction

	function automatic void add_unit(input bit [7:0] hdr, input int body_len,
			input bit [23:0] trip, input bit use_trip);
		bit [7:0] b;
		add_start();
		add_byte(hdr);
		for (int i = 0; i < body_len; i++) begin
			if (use_trip && i < 3)
				b = trip[8 * (2 - i) +: 8];
			else
				b = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
			add_byte(b);
		end
		repeat ($urandom_range(0, 2))
			put_byte(8'h00);
	endfunction

	// Most streams are well formed; the rest carry one defect each or are plain noise.
	function automatic void build_stream();
		int kind;
		int pick;
		bit [4:0] ntype;
		bit [23:0] trip;
		stream_bytes.delete();
		kind = $urandom_range(0, 19);
		trip = 24'($urandom);
		if (trip == 24'h000001)
			trip = 24'h000002;
		case (kind)
			18: begin
				case ($urandom_range(0, 2))
					0: put_byte(8'($urandom_range(2, 255)));
					1: begin
						put_byte(8'h00);
						put_byte(8'h01);
					end
					default: repeat ($urandom_range(1, 4)) put_byte(8'h00);
				endcase
			end
			19: begin
				if ($urandom_range(0, 1) == 1)
					add_start();
				repeat ($urandom_range(1, 20))
					put_byte(8'($urandom));
			end
			default: begin
				if (kind != 13)
					add_unit(nal_hdr(TYPE_SPS),
						(kind == 15) ? $urandom_range(0, 2) : $urandom_range(3, 8), trip, 1'b1);
				if (kind != 12)
					add_unit(nal_hdr(TYPE_PPS), $urandom_range(0, 5), trip, 1'b0);
				if (kind == 16)
					add_unit(nal_hdr(TYPE_SPS), $urandom_range(3, 8),
						trip ^ (24'h1 << $urandom_range(0, 23)), 1'b1);
				if (kind == 14)
					add_unit(nal_hdr(5'($urandom)) | FORBIDDEN_BIT, $urandom_range(0, 4),
						trip, 1'b0);
				// A bare start code gives an empty unit, or ends the stream on a start code.
				if (kind == 17)
					add_start();
				repeat ($urandom_range(0, 3)) begin
					pick = $urandom_range(0, 5);
					if (pick == 0) begin
						add_unit(nal_hdr(TYPE_SPS), $urandom_range(3, 8), trip, 1'b1);
					end else if (pick == 1) begin
						add_unit(nal_hdr(TYPE_PPS), $urandom_range(0, 5), trip, 1'b0);
					end else begin
						ntype = 5'($urandom_range(1, 29));
						if (ntype >= 5'd7)
							ntype = ntype + 5'd2;
						add_unit(nal_hdr(ntype), $urandom_range(0, 8), trip, 1'b0);
					end
				end
			end
		endcase
	endfunction

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		clear_splitter();
		idling = 1'b1;
		bytes_examined = 0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);

		for (int i = 0; i < $size(DIRECTED_ROWS); i++)
			push_byte(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].fin, DIRECTED_ROWS[i].typed,
				DIRECTED_ROWS[i].want);
		drain_reports();

		bytes_examined = 0;
		while (bytes_examined < 500) begin
			idling = ($urandom_range(0, 3) != 0);
			build_stream();
			foreach (stream_bytes[k])
				push_byte(stream_bytes[k], k == stream_bytes.size() - 1, 1'b0, '0);
		end

		drain_reports();
		repeat (10) @(posedge clk);
		if (!failed && pending_reports.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
